FILE: design/lpg_pkg.sv
// Shared constants and opcode type for the permutation generator.
package lpg_pkg;

  localparam int MAX_ELEMENTS_DEF = 8;
  localparam int DATA_W           = 32;
  localparam int POS_W            = 3;
  localparam int OP_W             = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_NEXT  = 2'd2
  } op_t;

endpackage

FILE: design/lpg_if.sv
// Request and result channel interfaces of the permutation generator.
interface lpg_cmd_if;
  import lpg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface lpg_perm_if;
  import lpg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element;
  logic [POS_W-1:0]         position;
  logic                     last;
  logic                     exhausted;

  modport source (output valid, output element, output position, output last,
                  output exhausted, input ready);
  modport sink   (input valid, input element, input position, input last,
                  input exhausted, output ready);
endinterface

FILE: design/lpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lpg_cmp.sv
// Shared signed less-than unit used by the sort, pivot and swap steps.
module lpg_cmp (
  input  logic signed [lpg_pkg::DATA_W-1:0] a,
  input  logic signed [lpg_pkg::DATA_W-1:0] b,
  output logic                              lt
);
  import lpg_pkg::*;

  assign lt = (a < b);

endmodule

FILE: design/lexicographic_permutation_generator.sv
// Load writes one element. Start on n elements: accept, then (n-1) sort passes, then emit.
// Next: pivot scan from the right, then a suffix of m elements gets (m-1) sort passes,
// then the swap search, then emit.
// Emit runs one element per cycle through the result register unless the sink stalls.
// The element store has a single read port, and the comparator is shared by the sort, pivot and swap steps.
// Reset clears the state, the count, the started flag and the result valid flag; stored values are not cleared.
module lexicographic_permutation_generator #(
  parameter int MAX_ELEMENTS = lpg_pkg::MAX_ELEMENTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lpg_cmd_if.sink    cmd,
  lpg_perm_if.source perm
);
  import lpg_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_SORT_START = 13'b0000000000010,
    S_SORT_FIRST = 13'b0000000000100,
    S_SORT       = 13'b0000000001000,
    S_SORT_END   = 13'b0000000010000,
    S_PIV_FIRST  = 13'b0000000100000,
    S_PIV        = 13'b0000001000000,
    S_SWAP_START = 13'b0000010000000,
    S_SWAP       = 13'b0000100000000,
    S_SWAP_WR    = 13'b0001000000000,
    S_EMIT_START = 13'b0010000000000,
    S_EMIT       = 13'b0100000000000,
    S_EXH        = 13'b1000000000000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              started, started_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  passes, passes_next;
  logic              swap_after, swap_after_next;
  logic [DATA_W-1:0] hold, hold_next;
  logic [DATA_W-1:0] pivot_val, pivot_val_next;

  logic              out_valid, out_valid_next;
  logic [DATA_W-1:0] out_element, out_element_next;
  logic [POS_W-1:0]  out_position, out_position_next;
  logic              out_last, out_last_next;
  logic              out_exhausted, out_exhausted_next;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [CNT_W-1:0]  raddr_full;
  logic [DATA_W-1:0] rdata;

  logic [DATA_W-1:0] cmp_a, cmp_b;
  logic              cmp_lt;

  logic              cmd_accept;
  logic              out_free;
  logic [CNT_W-1:0]  idx_inc, idx_dec, suffix_len;

  lpg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_full[IDX_W-1:0]),
    .rdata (rdata)
  );

  lpg_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign cmd.ready      = (state == S_IDLE);
  assign cmd_accept     = cmd.valid && cmd.ready;
  assign out_free       = !out_valid || perm.ready;
  assign idx_inc        = idx + ONE;
  assign idx_dec        = idx - ONE;
  assign suffix_len     = count - idx - ONE;

  assign perm.valid     = out_valid;
  assign perm.element   = out_element;
  assign perm.position  = out_position;
  assign perm.last      = out_last;
  assign perm.exhausted = out_exhausted;

  // Comparator operands: pivot value against the suffix in the swap search,
  // otherwise the fresh read against the held element.
  always_comb begin
    if (state == S_SWAP) begin
      cmp_a = pivot_val;
      cmp_b = rdata;
    end else begin
      cmp_a = rdata;
      cmp_b = hold;
    end
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    started_next       = started;
    idx_next           = idx;
    lo_next            = lo;
    passes_next        = passes;
    swap_after_next    = swap_after;
    hold_next          = hold;
    pivot_val_next     = pivot_val;
    out_valid_next     = out_valid && !perm.ready;
    out_element_next   = out_element;
    out_position_next  = out_position;
    out_last_next      = out_last;
    out_exhausted_next = out_exhausted;
    we                 = 1'b0;
    waddr              = idx[IDX_W-1:0];
    wdata              = hold;
    raddr_full         = idx;

    case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          case (cmd.opcode)
            OP_LOAD: begin
              if (count < MAX_CNT) begin
                we         = 1'b1;
                waddr      = count[IDX_W-1:0];
                wdata      = cmd.value;
                count_next = count + ONE;
              end
              started_next = 1'b0;
            end
            OP_START: begin
              started_next = 1'b1;
              if (count >= TWO) begin
                lo_next         = '0;
                passes_next     = count - ONE;
                swap_after_next = 1'b0;
                state_next      = S_SORT_START;
              end else if (count == ONE) begin
                state_next = S_EMIT_START;
              end
            end
            OP_NEXT: begin
              if (started) begin
                if (count < TWO) begin
                  state_next = S_EXH;
                end else begin
                  raddr_full = count - ONE;
                  idx_next   = count - ONE;
                  state_next = S_PIV_FIRST;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SORT_START: begin
        raddr_full = lo;
        state_next = S_SORT_FIRST;
      end

      S_SORT_FIRST: begin
        hold_next  = rdata;
        raddr_full = lo + ONE;
        idx_next   = lo + ONE;
        state_next = S_SORT;
      end

      // One bubble step: write back the smaller, carry the larger upward.
      S_SORT: begin
        we    = 1'b1;
        waddr = idx_dec[IDX_W-1:0];
        wdata = cmp_lt ? rdata : hold;
        if (!cmp_lt) begin
          hold_next = rdata;
        end
        if (idx_inc < count) begin
          raddr_full = idx_inc;
          idx_next   = idx_inc;
        end else begin
          state_next = S_SORT_END;
        end
      end

      S_SORT_END: begin
        we          = 1'b1;
        waddr       = idx[IDX_W-1:0];
        wdata       = hold;
        passes_next = passes - ONE;
        if (passes == ONE) begin
          state_next = swap_after ? S_SWAP_START : S_EMIT_START;
        end else begin
          state_next = S_SORT_START;
        end
      end

      S_PIV_FIRST: begin
        hold_next  = rdata;
        raddr_full = idx_dec;
        idx_next   = idx_dec;
        state_next = S_PIV;
      end

      // Scan right to left for the first element below its right neighbor.
      S_PIV: begin
        if (cmp_lt) begin
          pivot_val_next = rdata;
          lo_next        = idx_inc;
          if (suffix_len >= TWO) begin
            passes_next     = suffix_len - ONE;
            swap_after_next = 1'b1;
            state_next      = S_SORT_START;
          end else begin
            state_next = S_SWAP_START;
          end
        end else begin
          hold_next = rdata;
          if (idx == '0) begin
            state_next = S_EXH;
          end else begin
            raddr_full = idx_dec;
            idx_next   = idx_dec;
          end
        end
      end

      S_SWAP_START: begin
        raddr_full = lo;
        idx_next   = lo;
        state_next = S_SWAP;
      end

      S_SWAP: begin
        if (cmp_lt) begin
          we         = 1'b1;
          waddr      = idx[IDX_W-1:0];
          wdata      = pivot_val;
          hold_next  = rdata;
          state_next = S_SWAP_WR;
        end else if (idx_inc < count) begin
          raddr_full = idx_inc;
          idx_next   = idx_inc;
        end else begin
          state_next = S_EMIT_START;
        end
      end

      S_SWAP_WR: begin
        we         = 1'b1;
        waddr      = lo[IDX_W-1:0] - 1'b1;
        wdata      = hold;
        state_next = S_EMIT_START;
      end

      S_EMIT_START: begin
        raddr_full = '0;
        idx_next   = '0;
        state_next = S_EMIT;
      end

      // Read data holds while the address holds, so a stalled sink just waits.
      S_EMIT: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          out_element_next   = rdata;
          out_position_next  = POS_W'(idx);
          out_last_next      = (idx_inc == count);
          out_exhausted_next = 1'b0;
          if (idx_inc == count) begin
            state_next = S_IDLE;
          end else begin
            raddr_full = idx_inc;
            idx_next   = idx_inc;
          end
        end
      end

      S_EXH: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          out_element_next   = '0;
          out_position_next  = '0;
          out_last_next      = 1'b1;
          out_exhausted_next = 1'b1;
          state_next         = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      started   <= started_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx           <= idx_next;
    lo            <= lo_next;
    passes        <= passes_next;
    swap_after    <= swap_after_next;
    hold          <= hold_next;
    pivot_val     <= pivot_val_next;
    out_element   <= out_element_next;
    out_position  <= out_position_next;
    out_last      <= out_last_next;
    out_exhausted <= out_exhausted_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("element count above capacity");

  a_load_grows: assert property (@(posedge clk) disable iff (rst)
    cmd_accept && (cmd.opcode == OP_LOAD) && (count < MAX_CNT)
    |=> count == $past(count) + ONE)
    else $error("accepted load did not grow the store");

  a_exh_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_exhausted |-> out_last && (out_position == '0))
    else $error("exhausted result not a single last element");

  a_no_write_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) || (state == S_EMIT_START) || (state == S_EXH) |-> !we)
    else $error("store written while emitting");

  a_emit_only_started: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> started)
    else $error("emitting without a start");

endmodule

FILE: bench/lexicographic_permutation_generator_tb.sv
// Self-checking bench: directed and random requests, results scored against typed expectations or a permutation model.
module lexicographic_permutation_generator_tb;
  import lpg_pkg::*;

  localparam int PERM_MAX    = MAX_ELEMENTS_DEF;
  localparam int DIR_ROWS    = 24;
  localparam int RAND_ITEMS  = 96;
  localparam int MAX_WAIT    = 13;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_TIME  = 5000000;

  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0] VAL_MIN   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_DUP   = 32'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         position;
    logic                     last;
    logic                     exhausted;
  } perm_result_t;

  // literal: expectation typed in the row; one_result: the row yields res, else nothing
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data;
    logic              literal;
    logic              one_result;
    perm_result_t      res;
  } request_row_t;

  localparam perm_result_t NO_RES  = {32'd0, 3'd0, 1'b0, 1'b0};
  localparam perm_result_t EXH_RES = {32'd0, 3'd0, 1'b1, 1'b1};
  localparam perm_result_t MIN_RES = {VAL_MIN, 3'd0, 1'b1, 1'b0};

  logic clk = 1'b0;
  logic rst;

  lpg_cmd_if  req_bus ();
  lpg_perm_if res_bus ();

  lexicographic_permutation_generator #(.MAX_ELEMENTS(PERM_MAX)) DUT (
    .clk  (clk),
    .rst  (rst),
    .cmd  (req_bus),
    .perm (res_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Permutation model state
  logic signed [DATA_W-1:0] perm_store [PERM_MAX];
  int                       perm_count = 0;
  bit                       perm_started = 1'b0;
  perm_result_t             fresh_q [$];

  perm_result_t  pending_q [$];
  request_row_t  req_q [$];
  int            reqs_accepted = 0;
  int            errors = 0;
  logic          hold_sink;

  function automatic void sort_span(int lo, int hi);
    logic signed [DATA_W-1:0] t;
    for (int i = lo; i + 1 < hi; i++)
      for (int j = lo; j + 1 < hi; j++)
        if (perm_store[j+1] < perm_store[j]) begin
          t = perm_store[j];
          perm_store[j] = perm_store[j+1];
          perm_store[j+1] = t;
        end
  endfunction

  function automatic void emit_perm();
    perm_result_t r;
    for (int k = 0; k < perm_count; k++) begin
      r.element   = perm_store[k];
      r.position  = POS_W'(k);
      r.last      = (k + 1 == perm_count);
      r.exhausted = 1'b0;
      fresh_q.push_back(r);
    end
  endfunction

  // Apply one request to the model; results land in fresh_q
  function automatic void step_perm(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] data);
    int pivot;
    bit swapped;
    logic signed [DATA_W-1:0] t;
    fresh_q.delete();
    pivot = 0;
    swapped = 1'b0;
    case (op)
      OP_LOAD: begin
        if (perm_count < PERM_MAX) begin
          perm_store[perm_count] = data;
          perm_count++;
        end
        perm_started = 1'b0;
      end
      OP_START: begin
        sort_span(0, perm_count);
        perm_started = 1'b1;
        emit_perm();
      end
      OP_NEXT: begin
        if (perm_started) begin
          for (int k = perm_count; k > 1 && pivot == 0; k--)
            if (perm_store[k-2] < perm_store[k-1]) pivot = k - 1;
          if (pivot == 0) begin
            fresh_q.push_back(EXH_RES);
          end else begin
            sort_span(pivot, perm_count);
            for (int k = pivot; k < perm_count && !swapped; k++)
              if (perm_store[pivot-1] < perm_store[k]) begin
                t = perm_store[pivot-1];
                perm_store[pivot-1] = perm_store[k];
                perm_store[k] = t;
                swapped = 1'b1;
              end
            emit_perm();
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic request_row_t directed_row(int idx);
    case (idx)
      0:  return {OP_NEXT,   32'd0,         1'b1, 1'b0, NO_RES};  // next before start
      1:  return {OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_RES};
      2:  return {OP_START,  32'd0,         1'b1, 1'b0, NO_RES};  // start on empty store
      3:  return {OP_NEXT,   32'd0,         1'b1, 1'b1, EXH_RES};
      4:  return {OP_LOAD,   VAL_MIN,       1'b1, 1'b0, NO_RES};
      5:  return {OP_START,  32'd0,         1'b1, 1'b1, MIN_RES};
      6:  return {OP_NEXT,   32'd0,         1'b1, 1'b1, EXH_RES}; // single element
      7:  return {OP_LOAD,   VAL_MAX,       1'b1, 1'b0, NO_RES};  // load after start
      8:  return {OP_NEXT,   32'd0,         1'b1, 1'b0, NO_RES};
      9:  return {OP_START,  32'd0,         1'b0, 1'b0, NO_RES};
      10: return {OP_NEXT,   32'd0,         1'b0, 1'b0, NO_RES};
      11: return {OP_NEXT,   32'd0,         1'b1, 1'b1, EXH_RES};
      12: return {OP_LOAD,   VAL_DUP,       1'b1, 1'b0, NO_RES};
      13: return {OP_LOAD,   VAL_DUP,       1'b1, 1'b0, NO_RES};
      14: return {OP_START,  32'd0,         1'b0, 1'b0, NO_RES};
      15: return {OP_NEXT,   32'd0,         1'b0, 1'b0, NO_RES};
      16: return {OP_LOAD,   VAL_DUP,       1'b1, 1'b0, NO_RES};
      17: return {OP_LOAD,   VAL_DUP,       1'b1, 1'b0, NO_RES};
      18: return {OP_LOAD,   VAL_DUP,       1'b1, 1'b0, NO_RES};
      19: return {OP_LOAD,   VAL_DUP,       1'b1, 1'b0, NO_RES};
      20: return {OP_LOAD,   32'h1234_5678, 1'b1, 1'b0, NO_RES};  // store full
      21: return {OP_START,  32'd0,         1'b0, 1'b0, NO_RES};
      22: return {OP_NEXT,   32'd0,         1'b0, 1'b0, NO_RES};
      default: return {OP_UNUSED, 32'd0,    1'b1, 1'b0, NO_RES};
    endcase
  endfunction

  function automatic void queue_req(logic [OP_W-1:0] op, logic [DATA_W-1:0] data);
    request_row_t row;
    row = {op, data, 1'b0, 1'b0, NO_RES};
    req_q.push_back(row);
  endfunction

  // Each start is followed by a run of nexts, often long enough to exhaust the store
  function automatic void build_random();
    int counted;
    int run_len;
    counted = 0;
    while (counted < RAND_ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin
          queue_req(OP_LOAD, $urandom());
          queue_req(OP_NEXT, $urandom());
        end
        1: queue_req(OP_UNUSED, $urandom());
        default: ;
      endcase
      queue_req(OP_START, $urandom());
      counted++;
      run_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : $urandom_range(50, 70);
      for (int k = 0; k < run_len && counted < RAND_ITEMS; k++) begin
        if ($urandom_range(0, 19) == 0) queue_req(OP_UNUSED, $urandom());
        queue_req(OP_NEXT, $urandom());
        counted++;
      end
    end
  endfunction

  // Request side: reset, then walk the table and the random stream
  initial begin
    request_row_t row;
    int gap;
    bit src_burst;
    rst <= 1'b1;
    req_bus.valid  <= 1'b0;
    req_bus.opcode <= '0;
    req_bus.value  <= '0;
    src_burst = 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) req_q.push_back(directed_row(i));
    build_random();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (req_q[i]) begin
      row = req_q[i];
      if ($urandom_range(0, 11) == 0) src_burst = !src_burst;
      gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= row.op;
      req_bus.value  <= row.data;
      do @(posedge clk); while (!req_bus.ready);
      step_perm(row.op, row.data);
      if (row.literal) begin
        if (row.one_result) pending_q.push_back(row.res);
      end else begin
        foreach (fresh_q[k]) pending_q.push_back(fresh_q[k]);
      end
      reqs_accepted++;
    end
    req_bus.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stalls, score every accepted result
  initial begin
    perm_result_t want;
    int sink_wait;
    bit sink_burst;
    res_bus.ready <= 1'b0;
    sink_burst = 1'b0;
    sink_wait = $urandom_range(0, MAX_WAIT);
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (res_bus.valid && res_bus.ready) begin
          if (pending_q.size() == 0) begin
            $error("unexpected result: element %0d position %0d", res_bus.element,
                   res_bus.position);
            errors++;
          end else begin
            want = pending_q.pop_front();
            if (res_bus.element !== want.element) begin
              $error("element: expected %0d, got %0d", want.element, res_bus.element);
              errors++;
            end
            if (res_bus.position !== want.position) begin
              $error("position: expected %0d, got %0d", want.position, res_bus.position);
              errors++;
            end
            if (res_bus.last !== want.last) begin
              $error("last: expected %0d, got %0d", want.last, res_bus.last);
              errors++;
            end
            if (res_bus.exhausted !== want.exhausted) begin
              $error("exhausted: expected %0d, got %0d", want.exhausted, res_bus.exhausted);
              errors++;
            end
          end
          if ($urandom_range(0, 23) == 0) sink_burst = !sink_burst;
          sink_wait = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end else if (sink_wait > 0) begin
          sink_wait--;
        end
        res_bus.ready <= (sink_wait == 0) && !hold_sink;
      end
    end
  end

  // Hold off the result side long enough for the request side to back up
  initial begin
    hold_sink <= 1'b0;
    wait (reqs_accepted >= DIR_ROWS + 6);
    hold_sink <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_sink <= 1'b0;
  end

  initial begin
    #(LIMIT_TIME);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
